FILE: src/bipg_pkg.sv
// Shared types, constants and the digit font for the battery icon pixel generator.
// No dependencies; every other file in the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bipg_pkg;

   localparam int CFG_W     = 12;
   localparam int LVL_W     = 7;
   localparam int PIX_W     = 12;
   localparam int COLOR_W   = 32;
   localparam int LAYER_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int POS_W     = 14;  // signed screen coordinate, icon may hang off the edge
   localparam int W_W       = 10;  // icon width, at most 4095/6

   localparam int GEOM_STAGES = 5;

   localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd1920;
   localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd1080;
   localparam logic [LVL_W-1:0] CHARGE_LEVEL_RESET  = 7'd0;

   localparam int LEVEL_MAX        = 100;
   localparam int LEVEL_RED_MAX    = 20;
   localparam int LEVEL_YELLOW_MAX = 60;
   localparam int DIGIT_Y_LIFT     = 10;

   // Reciprocals for division by constants: floor(v * RECIP >> SHIFT) is exact
   // over the value range each one is used for.
   localparam int RECIP6    = 10923;   // >> 16, screen width up to 4095
   localparam int RECIP25   = 2622;    // >> 16, icon width up to 682
   localparam int RECIP10   = 205;     // >> 11, level up to 99
   localparam int RECIP100  = 167773;  // >> 24, product up to 136400

   localparam logic [COLOR_W-1:0] COLOR_NONE   = 32'h0000_0000;
   localparam logic [COLOR_W-1:0] COLOR_RED    = 32'hFFFF_0000;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 32'hFFFF_FF00;
   localparam logic [COLOR_W-1:0] COLOR_GREEN  = 32'hFF00_FF00;
   localparam logic [COLOR_W-1:0] COLOR_WHITE  = 32'hFFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_CHARGE_LEVEL  = 2'd2
   } csr_index_type;

   typedef enum logic [LAYER_W-1:0] {
      LAYER_OFF     = 3'd0,
      LAYER_BACK    = 3'd1,
      LAYER_OUTLINE = 3'd2,
      LAYER_FILL    = 3'd3,
      LAYER_DIGIT   = 3'd4
   } layer_type;

   typedef logic signed [POS_W-1:0] pos_type;

   // Icon geometry, all edges as half-open spans [left, right) and [top, bottom).
   typedef struct packed {
      pos_type              x_left;
      pos_type              x_right;
      pos_type              x_in_left;
      pos_type              x_in_right;
      pos_type              y_top;
      pos_type              y_bottom;
      pos_type              y_in_top;
      pos_type              y_in_bottom;
      pos_type              fill_top;
      pos_type              cap_left;
      pos_type              cap_right;
      pos_type              cap_top;
      pos_type              digit_left;
      pos_type              digit_top;
      logic [1:0]           digit_count;
      logic [3:0]           digit0;
      logic [3:0]           digit1;
      logic [3:0]           digit2;
      logic [COLOR_W-1:0]   fill_color;
   } geom_type;

   localparam logic [7:0] GLYPH_ROM [0:9][0:11] = '{
      '{8'h3C,8'h7E,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'hC3,8'h7E,8'h3C},
      '{8'h18,8'h38,8'h78,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h7E,8'h7E},
      '{8'h3C,8'h7E,8'hC3,8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'hC0,8'hFF,8'hFF},
      '{8'h7E,8'hFF,8'h03,8'h03,8'h1E,8'h1E,8'h03,8'h03,8'h03,8'h03,8'hFF,8'h7E},
      '{8'h06,8'h0E,8'h1E,8'h36,8'h66,8'hC6,8'hFF,8'hFF,8'h06,8'h06,8'h06,8'h06},
      '{8'hFF,8'hFF,8'hC0,8'hC0,8'hFC,8'hFE,8'h06,8'h03,8'h03,8'hC3,8'h7E,8'h3C},
      '{8'h3E,8'h7F,8'hE3,8'hC0,8'hFC,8'hFE,8'hC3,8'hC3,8'hC3,8'hE3,8'h7E,8'h3C},
      '{8'hFF,8'hFF,8'h03,8'h06,8'h0C,8'h18,8'h30,8'h30,8'h60,8'h60,8'h60,8'h60},
      '{8'h3C,8'h7E,8'hC3,8'hC3,8'h7E,8'h7E,8'hC3,8'hC3,8'hC3,8'hC3,8'h7E,8'h3C},
      '{8'h3C,8'h7E,8'hC3,8'hC3,8'hCF,8'hDF,8'hFB,8'h7F,8'h03,8'h03,8'h7E,8'h3C}
   };

   function automatic logic [7:0] glyph_row(input logic [3:0] digit, input logic [3:0] row);
      logic [7:0] bits;
      bits = 8'h00;
      if (digit <= 4'd9 && row <= 4'd11) begin
         bits = GLYPH_ROM[digit][row];
      end
      return bits;
   endfunction

   function automatic pos_type as_pos(input logic [CFG_W-1:0] v);
      return pos_type'({{(POS_W-CFG_W){1'b0}}, v});
   endfunction

endpackage

`default_nettype wire

FILE: src/bipg_if.sv
// Valid/ready channel interfaces for pixel requests and pixel responses.
// Depends on bipg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bipg_req_if;
   import bipg_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bipg_rsp_if;
   import bipg_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;
   logic [LAYER_W-1:0] layer;

   modport source (output valid, output pixel_color, output layer, input ready);
   modport sink   (input valid, input pixel_color, input layer, output ready);
endinterface

`default_nettype wire

FILE: src/bipg_geometry.sv
// Five-stage free-running pipeline that derives the icon geometry from the
// screen size and charge level registers. Depends on bipg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bipg_geometry #(
   parameter int DIGIT_SCALE = 2
) (
   input  logic                        clock,
   input  logic [bipg_pkg::CFG_W-1:0]  screen_width,
   input  logic [bipg_pkg::CFG_W-1:0]  screen_height,
   input  logic [bipg_pkg::LVL_W-1:0]  charge_level,
   output bipg_pkg::geom_type          geom
);
   import bipg_pkg::*;

   localparam int DW = 8 * DIGIT_SCALE;

   // stage 1: icon width, clamped level
   logic [W_W-1:0]   w1_in, w1_ff;
   logic [LVL_W-1:0] lvl1_in, lvl1_ff;
   logic [CFG_W-1:0] sw1_ff, sh1_ff;
   logic [25:0]      w_prod;

   // stage 2: border, height, origin, tens digit
   logic [W_W-1:0]   w2_ff;
   logic [4:0]       b2_in, b2_ff;
   logic [W_W:0]     h2_in, h2_ff;
   pos_type          x0_2_in, x0_2_ff, y0_2_in, y0_2_ff;
   logic [LVL_W-1:0] lvl2_ff;
   logic [3:0]       ten2_in, ten2_ff;
   logic             hun2_in, hun2_ff;
   logic [21:0]      b_prod;
   logic [14:0]      ten_prod;
   logic [CFG_W-1:0] x_span;
   pos_type          y_span, y_adj;

   // stage 3: edges, digit placement, fill product
   geom_type         geo3_in, geo3_ff;
   logic [17:0]      prod3_in, prod3_ff;
   logic [W_W:0]     fill_span;
   logic [LVL_W-1:0] one_diff;
   logic [3:0]       one3;
   logic [W_W-1:0]   cw3;
   pos_type          cx3, cy3;

   // stage 4: fill height
   geom_type         geo4_ff;
   logic [W_W:0]     fh4_in, fh4_ff;
   logic [35:0]      fh_prod;

   // stage 5: fill top edge
   geom_type         geo5_in, geo5_ff;

   always_comb begin
      w_prod  = {14'b0, screen_width} * 26'(RECIP6);
      w1_in   = w_prod[25:16];
      lvl1_in = (charge_level > LVL_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : charge_level;
   end

   always_ff @(posedge clock) begin
      w1_ff   <= w1_in;
      lvl1_ff <= lvl1_in;
      sw1_ff  <= screen_width;
      sh1_ff  <= screen_height;
   end

   always_comb begin
      b_prod  = {12'b0, w1_ff} * 22'(RECIP25);
      b2_in   = b_prod[20:16];
      h2_in   = {w1_ff, 1'b0};
      x_span  = sw1_ff - {2'b0, w1_ff};
      x0_2_in = pos_type'({{(POS_W-CFG_W+1){1'b0}}, x_span[CFG_W-1:1]});
      // signed halving that truncates toward zero
      y_span  = as_pos(sh1_ff) - as_pos({1'b0, h2_in});
      y_adj   = y_span + pos_type'({{(POS_W-1){1'b0}}, y_span[POS_W-1]});
      y0_2_in = y_adj >>> 1;
      hun2_in = (lvl1_ff == LVL_W'(LEVEL_MAX));
      ten_prod = {8'b0, lvl1_ff} * 15'(RECIP10);
      ten2_in = hun2_in ? 4'd0 : ten_prod[14:11];
   end

   always_ff @(posedge clock) begin
      w2_ff   <= w1_ff;
      b2_ff   <= b2_in;
      h2_ff   <= h2_in;
      x0_2_ff <= x0_2_in;
      y0_2_ff <= y0_2_in;
      lvl2_ff <= lvl1_ff;
      ten2_ff <= ten2_in;
      hun2_ff <= hun2_in;
   end

   always_comb begin
      fill_span = h2_ff - {5'b0, b2_ff, 1'b0};
      prod3_in  = {7'b0, fill_span} * {11'b0, lvl2_ff};
      one_diff  = lvl2_ff - 7'({3'b0, ten2_ff} * 7'd10);
      one3      = hun2_ff ? 4'd0 : one_diff[3:0];
      cw3       = w2_ff >> 2;
      cx3       = x0_2_ff + as_pos({3'b0, w2_ff[W_W-1:1]});
      cy3       = y0_2_ff + as_pos({2'b0, w2_ff}) - pos_type'(DIGIT_Y_LIFT);

      geo3_in             = '0;
      geo3_in.x_left      = x0_2_ff;
      geo3_in.x_right     = x0_2_ff + as_pos({2'b0, w2_ff});
      geo3_in.x_in_left   = x0_2_ff + as_pos({7'b0, b2_ff});
      geo3_in.x_in_right  = geo3_in.x_right - as_pos({7'b0, b2_ff});
      geo3_in.y_top       = y0_2_ff;
      geo3_in.y_bottom    = y0_2_ff + as_pos({1'b0, h2_ff});
      geo3_in.y_in_top    = y0_2_ff + as_pos({7'b0, b2_ff});
      geo3_in.y_in_bottom = geo3_in.y_bottom - as_pos({7'b0, b2_ff});
      geo3_in.cap_left    = x0_2_ff
                          + as_pos({3'b0, 9'((w2_ff - cw3) >> 1)});
      geo3_in.cap_right   = geo3_in.cap_left + as_pos({2'b0, cw3});
      geo3_in.cap_top     = y0_2_ff - as_pos({2'b0, cw3});
      geo3_in.digit_top   = cy3 - pos_type'(6 * DIGIT_SCALE);

      // leading zeros are dropped: one digit below ten, three at full charge
      if (hun2_ff) begin
         geo3_in.digit_count = 2'd3;
         geo3_in.digit_left  = cx3 - pos_type'(2 * DW);
         geo3_in.digit0      = 4'd1;
         geo3_in.digit1      = ten2_ff;
         geo3_in.digit2      = one3;
      end else if (ten2_ff != 4'd0) begin
         geo3_in.digit_count = 2'd2;
         geo3_in.digit_left  = cx3 - pos_type'(DW + DW / 2);
         geo3_in.digit0      = ten2_ff;
         geo3_in.digit1      = one3;
      end else begin
         geo3_in.digit_count = 2'd1;
         geo3_in.digit_left  = cx3 - pos_type'(DW / 2);
         geo3_in.digit0      = one3;
      end

      if (lvl2_ff <= LVL_W'(LEVEL_RED_MAX)) begin
         geo3_in.fill_color = COLOR_RED;
      end else if (lvl2_ff <= LVL_W'(LEVEL_YELLOW_MAX)) begin
         geo3_in.fill_color = COLOR_YELLOW;
      end else begin
         geo3_in.fill_color = COLOR_GREEN;
      end
   end

   always_ff @(posedge clock) begin
      geo3_ff  <= geo3_in;
      prod3_ff <= prod3_in;
   end

   always_comb begin
      fh_prod = {18'b0, prod3_ff} * 36'(RECIP100);
      fh4_in  = fh_prod[34:24];
   end

   always_ff @(posedge clock) begin
      geo4_ff <= geo3_ff;
      fh4_ff  <= fh4_in;
   end

   always_comb begin
      geo5_in          = geo4_ff;
      geo5_in.fill_top = geo4_ff.y_in_bottom - as_pos({1'b0, fh4_ff});
   end

   always_ff @(posedge clock) begin
      geo5_ff <= geo5_in;
   end

   assign geom = geo5_ff;

endmodule

`default_nettype wire

FILE: src/battery_icon_pixel_generator.sv
// Top level of the battery icon pixel generator: registers, pixel pipeline, checks.
// Depends on bipg_pkg, bipg_if (channel interfaces) and bipg_geometry.
`timescale 1ns / 1ps
`default_nettype none

// Overlay generator for a battery icon centered on the screen.
//
// Use: write screen_width, screen_height and charge_level through the csr_
// port (index 0, 1, 2; other indexes are dropped), then stream pixel
// coordinates on req_chan. Each request beat yields one response beat on
// rsp_chan with the ARGB color and the winning layer (off screen, background,
// outline or cap, fill, digit).
//
// Timing: one beat per cycle while the receiver is ready and no refill is running.
// Each pixel is classified by one compare and lookup stage between the input
// register and the response register; the icon geometry is precomputed by a
// five-stage pipeline from the register values.
//
// Reset sets 1920 x 1080 at level 0. After reset or after any register write
// req_chan.ready stays low while the geometry pipeline refills. When the
// receiver stalls, the response register holds its beat and the input
// register still takes one more request before ready drops.
module battery_icon_pixel_generator #(
   parameter int DIGIT_SCALE = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bipg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bipg_pkg::CFG_W-1:0]      csr_wdata,
   bipg_req_if.sink                        req_chan,
   bipg_rsp_if.source                      rsp_chan
);
   import bipg_pkg::*;

   localparam int DW        = 8 * DIGIT_SCALE;
   localparam int DH        = 12 * DIGIT_SCALE;
   localparam int OFF_W     = $clog2(3 * DW);
   localparam int REM_W     = $clog2(DW);
   localparam int ROW_OFF_W = $clog2(DH);
   localparam int GEOM_WAIT = GEOM_STAGES - 1;
   localparam int WAIT_W    = $clog2(GEOM_STAGES);

   // configuration registers
   logic [CFG_W-1:0] screen_width_ff, screen_height_ff;
   logic [LVL_W-1:0] charge_level_ff;
   logic [WAIT_W-1:0] wait_in, wait_ff;
   logic             geom_busy;
   geom_type         geom;

   // pixel pipeline
   logic             acc, adv, out_free;
   logic             v1_in, v1_ff;
   logic [PIX_W-1:0] px1_ff, py1_ff;
   logic             out_v_in, out_v_ff;
   logic [COLOR_W-1:0] color_in, color_ff;
   layer_type        layer_in, layer_ff;

   // classification
   pos_type          pxs, pys, dx, dy, digit_span;
   logic             off_screen, in_digit, digit_hit, fill_hit, box_hit, ring_hit, cap_hit;
   logic [OFF_W-1:0] dx_off, rem_full;
   logic [REM_W-1:0] rem;
   logic [ROW_OFF_W-1:0] dy_off;
   logic [1:0]       k;
   logic [2:0]       col;
   logic [3:0]       row, digit;
   logic [7:0]       row_bits;

   // Hold the registers; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         charge_level_ff  <= CHARGE_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            CSR_CHARGE_LEVEL:  charge_level_ff  <= csr_wdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   bipg_geometry #(
      .DIGIT_SCALE (DIGIT_SCALE)
   ) u_geometry (
      .clock         (clock),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .charge_level  (charge_level_ff),
      .geom          (geom)
   );

   // Block requests until the geometry pipeline has seen the latest register values.
   always_comb begin
      if (csr_we) begin
         wait_in = WAIT_W'(GEOM_WAIT);
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - WAIT_W'(1);
      end else begin
         wait_in = wait_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= WAIT_W'(GEOM_WAIT);
      end else begin
         wait_ff <= wait_in;
      end
   end

   assign geom_busy = csr_we || (wait_ff != '0);

   // Handshake: the input register advances whenever the response register
   // is empty or its beat is taken in this cycle.
   assign out_free       = !out_v_ff || rsp_chan.ready;
   assign adv            = v1_ff && out_free;
   assign req_chan.ready = !reset && !geom_busy && (!v1_ff || out_free);
   assign acc            = req_chan.valid && req_chan.ready;

   always_comb begin
      if (acc) begin
         v1_in = 1'b1;
      end else if (adv) begin
         v1_in = 1'b0;
      end else begin
         v1_in = v1_ff;
      end

      if (adv) begin
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         px1_ff <= req_chan.pixel_x;
         py1_ff <= req_chan.pixel_y;
      end
      if (adv) begin
         color_ff <= color_in;
         layer_ff <= layer_in;
      end
   end

   // Digit lookup: locate the glyph cell, then the font dot inside it.
   always_comb begin
      pxs = as_pos(px1_ff);
      pys = as_pos(py1_ff);
      off_screen = (px1_ff >= screen_width_ff) || (py1_ff >= screen_height_ff);

      case (geom.digit_count)
         2'd3:    digit_span = pos_type'(3 * DW);
         2'd2:    digit_span = pos_type'(2 * DW);
         default: digit_span = pos_type'(DW);
      endcase

      dx = pxs - geom.digit_left;
      dy = pys - geom.digit_top;
      in_digit = (dx >= 0) && (dx < digit_span) && (dy >= 0) && (dy < pos_type'(DH));
      dx_off = dx[OFF_W-1:0];
      dy_off = dy[ROW_OFF_W-1:0];

      if (dx_off >= OFF_W'(2 * DW)) begin
         k        = 2'd2;
         rem_full = dx_off - OFF_W'(2 * DW);
      end else if (dx_off >= OFF_W'(DW)) begin
         k        = 2'd1;
         rem_full = dx_off - OFF_W'(DW);
      end else begin
         k        = 2'd0;
         rem_full = dx_off;
      end
      rem = rem_full[REM_W-1:0];

      // divide the cell offsets by the dot size with independent compares
      col = 3'd0;
      for (int j = 1; j < 8; j++) begin
         col = col + {2'b0, (rem >= REM_W'(j * DIGIT_SCALE))};
      end
      row = 4'd0;
      for (int j = 1; j < 12; j++) begin
         row = row + {3'b0, (dy_off >= ROW_OFF_W'(j * DIGIT_SCALE))};
      end

      case (k)
         2'd1:    digit = geom.digit1;
         2'd2:    digit = geom.digit2;
         default: digit = geom.digit0;
      endcase
      row_bits  = glyph_row(digit, row);
      digit_hit = in_digit && row_bits[3'd7 - col];
   end

   // Fill, outline ring and cap tests against the precomputed edges.
   always_comb begin
      fill_hit = (pxs >= geom.x_in_left) && (pxs < geom.x_in_right)
              && (pys >= geom.fill_top) && (pys < geom.y_in_bottom);
      box_hit  = (pxs >= geom.x_left) && (pxs < geom.x_right)
              && (pys >= geom.y_top) && (pys < geom.y_bottom);
      ring_hit = box_hit
              && ((pys < geom.y_in_top) || (pys >= geom.y_in_bottom)
               || (pxs < geom.x_in_left) || (pxs >= geom.x_in_right));
      cap_hit  = (pxs >= geom.cap_left) && (pxs < geom.cap_right)
              && (pys >= geom.cap_top) && (pys < geom.y_top);
   end

   // Layer priority: off screen first, then digit over fill over outline or cap over background.
   always_comb begin
      if (off_screen) begin
         layer_in = LAYER_OFF;
         color_in = COLOR_NONE;
      end else if (digit_hit) begin
         layer_in = LAYER_DIGIT;
         color_in = COLOR_WHITE;
      end else if (fill_hit) begin
         layer_in = LAYER_FILL;
         color_in = geom.fill_color;
      end else if (ring_hit || cap_hit) begin
         layer_in = LAYER_OUTLINE;
         color_in = COLOR_WHITE;
      end else begin
         layer_in = LAYER_BACK;
         color_in = COLOR_NONE;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.pixel_color = color_ff;
   assign rsp_chan.layer       = layer_ff;

   // A register write must close the request side while geometry refills.
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_chan.ready)
      else $error("request accepted while geometry pipeline refills");

   // An accepted request beat must occupy the input register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      acc |=> v1_ff)
      else $error("accepted request beat lost");

   // Off screen and background beats carry no color.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.layer == LAYER_OFF || rsp_chan.layer == LAYER_BACK))
      |-> (rsp_chan.pixel_color == COLOR_NONE))
      else $error("color on an empty layer");

   // The input register never drains into a full, stalled response register.
   assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_chan.ready && v1_ff) |=> (out_v_ff && $stable(color_ff)))
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
